>>> hdl/magnetization_plateau_hull_macros.svh
// assertion macros for the plateau hull block
`ifndef MAGNETIZATION_PLATEAU_HULL_MACROS_SVH
`define MAGNETIZATION_PLATEAU_HULL_MACROS_SVH
`define MPH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/mph_pkg.sv
// ============================================================================
// mph_pkg
// types and constants shared by the plateau hull block
// ============================================================================
package mph_pkg;
   typedef struct packed {
      logic [15:0] magnetization;
      logic signed [31:0] energy;
      logic last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] field_h;
      logic [15:0] plateau_magnetization;
      logic signed [31:0] plateau_span;
      logic last_result;
   } rsp_type;

   typedef struct packed {
      logic load;           // write request point
      logic clr_count;
      logic hull_init;      // clear best, latch e[i], set k = i+1
      logic cand_cmp;       // compare candidate
      logic div_start;
      logic fill_wr;        // write field at fill index
      logic adv_i;
      logic out_init;
      logic out_emit;
   } cmd_type;

   typedef struct packed {
      logic cnt_lt2;
      logic hull_done;      // i+1 >= n
      logic cand_more;      // k < n
      logic div_done;
      logic fill_more;
      logic out_more;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction
endpackage

>>> hdl/magnetization_plateau_hull.sv
// ============================================================================
// magnetization_plateau_hull
// lower convex hull slopes of a magnetization curve
// ============================================================================
// Points load one per cycle while busy is low; the point with last_point set
// starts the hull walk and busy rises. Each hull step reads every later
// candidate once, waits on a serial divider and writes one field per
// covered point. Results then leave on rsp_valid, never back to back,
// and the receiver cannot stall them.
module magnetization_plateau_hull #(
   parameter int MAX_POINTS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  mph_pkg::req_type req_data,
   output logic rsp_valid,
   output mph_pkg::rsp_type rsp_data
);
   `include "magnetization_plateau_hull_macros.svh"
   mph_pkg::cmd_type cmd;
   mph_pkg::sts_type sts;
   logic last_out;

   mph_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .last_point(req_data.last_point),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );
   mph_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );

   assign last_out = rsp_valid && rsp_data.last_result;

   `MPH_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, busy, "result while idle")
   `MPH_ASSERT_NEXT(a_last_idle, clock, reset, last_out, !busy, "no idle after last")
   `MPH_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid, !rsp_valid, "results back to back")
endmodule

>>> hdl/mph_divider.sv
// ============================================================================
// mph_divider
// restoring divider, signed 33-bit dividend by 7-bit positive divisor
// ============================================================================
module mph_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [32:0] dividend,
   input  logic [6:0] divisor,
   output logic done,
   output logic signed [31:0] quotient
);
   logic [32:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0] div_ff, div_in;
   logic neg_ff, neg_in;
   logic [5:0] step_ff, step_in;
   logic run_ff, run_in, done_ff, done_in;
   logic [33:0] trial;
   logic signed [33:0] res;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; div_in = div_ff; neg_in = neg_ff;
      step_in = step_ff; run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[32]} - {27'd0, div_ff};
      if (start) begin
         neg_in = dividend[32];
         quo_in = dividend[32] ? 33'(-dividend) : 33'(dividend);
         rem_in = '0; div_in = divisor; step_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[32]};
            quo_in = {quo_ff[31:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd32) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; step_ff <= step_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; div_ff <= div_in; neg_ff <= neg_in;
   end

   assign res = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign quotient = mph_pkg::sat32(res);
   assign done = done_ff;
endmodule

>>> hdl/mph_datapath.sv
// ============================================================================
// mph_datapath
// point stores, hull candidate search, field stores and result formatting
// ============================================================================
module mph_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  logic clock,
   input  logic reset,
   input  mph_pkg::req_type req,
   input  mph_pkg::cmd_type cmd,
   output mph_pkg::sts_type sts,
   output mph_pkg::rsp_type rsp_data
);
   localparam int DEPTH = 64;
   logic [15:0] mag_mem [DEPTH];
   logic signed [31:0] eng_mem [DEPTH];
   logic signed [31:0] fld_mem [DEPTH];

   logic [6:0] cnt_ff, cnt_in, n_ff, i_ff, k_ff, bk_ff, f_ff;
   logic signed [32:0] bd_ff;
   logic [6:0] bn_ff;
   logic signed [31:0] ei_ff, ek_ff;
   logic signed [31:0] fq_ff;
   logic [15:0] mag_rd_ff;
   logic signed [31:0] f_rd_ff, f_nx_ff;
   logic div_done;
   logic signed [31:0] quotient;
   logic signed [32:0] d;
   logic [6:0] dn;
   logic signed [40:0] lhs, rhs;

   assign cnt_in = cmd.clr_count ? 7'd0 :
                   (cmd.load && cnt_ff < 7'(MAX_POINTS)) ? cnt_ff + 7'd1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && cnt_ff < 7'(MAX_POINTS)) begin
         mag_mem[cnt_ff[5:0]] <= req.magnetization;
         eng_mem[cnt_ff[5:0]] <= req.energy;
      end
      ek_ff <= eng_mem[k_ff[5:0]];
      mag_rd_ff <= mag_mem[f_ff[5:0]];
      f_rd_ff <= fld_mem[f_ff[5:0]];
      f_nx_ff <= fld_mem[6'(f_ff + 7'd1)];
      if (cmd.fill_wr) fld_mem[f_ff[5:0]] <= fq_ff;
   end

   assign d = 33'(ek_ff) - 33'(ei_ff);
   assign dn = k_ff - i_ff;
   assign lhs = 41'(d) * $signed({1'b0, bn_ff});
   assign rhs = 41'(bd_ff) * $signed({1'b0, dn});

   always_ff @(posedge clock) begin
      if (cmd.clr_count) begin
         n_ff <= cnt_ff; i_ff <= '0; k_ff <= '0;
      end
      if (cmd.hull_init) begin
         ei_ff <= ek_ff; bd_ff <= '0; bn_ff <= '0; k_ff <= i_ff + 7'd1;
      end
      if (cmd.cand_cmp) begin
         if (bn_ff == '0 || lhs < rhs) begin
            bd_ff <= d; bn_ff <= dn; bk_ff <= k_ff;
         end
         k_ff <= k_ff + 7'd1;
      end
      if (cmd.div_start) f_ff <= i_ff + 7'd1;
      if (div_done) fq_ff <= quotient;
      if (cmd.fill_wr) f_ff <= f_ff + 7'd1;
      if (cmd.adv_i) begin
         i_ff <= bk_ff; k_ff <= bk_ff;
      end
      if (cmd.out_init) f_ff <= 7'd1;
      if (cmd.out_emit) f_ff <= f_ff + 7'd1;
   end

   mph_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(bd_ff), .divisor(bn_ff), .done(div_done), .quotient(quotient)
   );

   assign sts.cnt_lt2 = cnt_ff < 7'd2;
   assign sts.hull_done = (i_ff + 7'd1) >= n_ff;
   assign sts.cand_more = k_ff < n_ff;
   assign sts.div_done = div_done;
   assign sts.fill_more = f_ff < bk_ff;
   assign sts.out_more = (f_ff + 7'd1) < n_ff;

   always_comb begin
      rsp_data.field_h = f_rd_ff;
      rsp_data.plateau_magnetization = mag_rd_ff;
      rsp_data.last_result = !sts.out_more;
      rsp_data.plateau_span = sts.out_more ?
         mph_pkg::sat32(34'(f_nx_ff) - 34'(f_rd_ff)) : 32'sd0;
   end
endmodule

>>> hdl/mph_controller.sv
// ============================================================================
// mph_controller
// sequencer for load, hull walk, division, field fill and result output
// ============================================================================
module mph_controller (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic last_point,
   input  mph_pkg::sts_type sts,
   output mph_pkg::cmd_type cmd,
   output logic busy,
   output logic rsp_valid
);
   localparam logic [3:0] S_LOAD = 4'd0, S_HRD = 4'd1, S_HINIT = 4'd2, S_CRD = 4'd3,
      S_CCMP = 4'd4, S_DIV = 4'd5, S_DWAIT = 4'd6, S_FILL = 4'd7, S_ADV = 4'd8,
      S_ORD = 4'd9, S_OEMIT = 4'd10, S_START = 4'd11, S_OOUT = 4'd12;
   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd = '0; state_in = state_ff; rsp_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_point) state_in = S_START;
            end
         end
         S_START: begin
            cmd.clr_count = 1'b1;
            state_in = sts.cnt_lt2 ? S_LOAD : S_HRD;
         end
         S_HRD: state_in = sts.hull_done ? S_ORD : S_HINIT;
         S_HINIT: begin cmd.hull_init = 1'b1; state_in = S_CRD; end
         S_CRD: state_in = sts.cand_more ? S_CCMP : S_DIV;
         S_CCMP: begin cmd.cand_cmp = 1'b1; state_in = S_CRD; end
         S_DIV: begin cmd.div_start = 1'b1; state_in = S_DWAIT; end
         S_DWAIT: if (sts.div_done) state_in = S_FILL;
         S_FILL: begin
            cmd.fill_wr = 1'b1;
            if (!sts.fill_more) state_in = S_ADV;
         end
         S_ADV: begin cmd.adv_i = 1'b1; state_in = S_HRD; end
         S_ORD: begin cmd.out_init = 1'b1; state_in = S_OEMIT; end
         S_OEMIT: begin
            state_in = S_OOUT;
         end
         S_OOUT: begin
            rsp_valid = 1'b1; cmd.out_emit = 1'b1;
            state_in = sts.out_more ? S_OEMIT : S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else state_ff <= state_in;
   end
   assign busy = state_ff != S_LOAD;
endmodule

>>> bench/magnetization_plateau_hull_test.sv
// ============================================================================
// magnetization_plateau_hull_test
// Loads data sets of points into the hull block and checks every emitted
// plateau against a local hull walk; covers saturation, ties, full store,
// single-point sets and mixed idle pressure on the request side.
// ============================================================================
module magnetization_plateau_hull_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 64;
   localparam int STALL_LIMIT = 200000;

   class plateau_scoreboard;
      logic [15:0]        mag_q [STORE_DEPTH];
      logic signed [31:0] energy_q [STORE_DEPTH];
      logic signed [31:0] field_q [STORE_DEPTH];
      int                 held;
      mph_pkg::rsp_type   pending [$];
      int                 errors;
      int                 results;

      function new();
         held = 0;
         errors = 0;
         results = 0;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void walk_hull(int n);
         int     i, k, best_k;
         longint best_d, best_n, d, dn;
         logic signed [31:0] f;
         i = 0;
         while (i + 1 < n) begin
            best_k = i + 1;
            best_d = longint'(energy_q[i + 1]) - longint'(energy_q[i]);
            best_n = 1;
            for (k = i + 2; k < n; k++) begin
               d = longint'(energy_q[k]) - longint'(energy_q[i]);
               dn = k - i;
               if (d * best_n < best_d * dn) begin
                  best_d = d;
                  best_n = dn;
                  best_k = k;
               end
            end
            f = clamp32(best_d / best_n);
            for (k = i + 1; k <= best_k; k++) field_q[k] = f;
            i = best_k;
         end
      endfunction

      function void note_request(mph_pkg::req_type r);
         int n;
         mph_pkg::rsp_type e;
         if (held < STORE_DEPTH) begin
            mag_q[held] = r.magnetization;
            energy_q[held] = r.energy;
            held++;
         end
         if (!r.last_point) return;
         n = held;
         held = 0;
         if (n < 2) return;
         walk_hull(n);
         for (int j = 1; j < n; j++) begin
            e.field_h = field_q[j];
            e.plateau_magnetization = mag_q[j];
            e.plateau_span = (j + 1 < n) ?
               clamp32(longint'(field_q[j + 1]) - longint'(field_q[j])) : 32'sd0;
            e.last_result = (j + 1 == n);
            pending.insert(pending.size(), e);
         end
      endfunction

      function void check_result(mph_pkg::rsp_type r);
         mph_pkg::rsp_type e;
         results++;
         if (pending.size() == 0) begin
            $error("unexpected result field_h %0d", r.field_h);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.field_h !== e.field_h) begin
            $error("field_h expected %0d actual %0d", e.field_h, r.field_h);
            errors++;
         end
         if (r.plateau_magnetization !== e.plateau_magnetization) begin
            $error("plateau_magnetization expected %0d actual %0d",
                   e.plateau_magnetization, r.plateau_magnetization);
            errors++;
         end
         if (r.plateau_span !== e.plateau_span) begin
            $error("plateau_span expected %0d actual %0d", e.plateau_span, r.plateau_span);
            errors++;
         end
         if (r.last_result !== e.last_result) begin
            $error("last_result expected %0d actual %0d", e.last_result, r.last_result);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   mph_pkg::req_type req_data;
   logic             rsp_valid;
   mph_pkg::rsp_type rsp_data;

   plateau_scoreboard plateaus = new();
   int idle_pct;
   int sent;
   int stall_cycles;

   magnetization_plateau_hull dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) plateaus.check_result(rsp_data);
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** magnetization_plateau_hull: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_point(logic [15:0] mag, logic signed [31:0] energy, logic last);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data.magnetization = mag;
      req_data.energy = energy;
      req_data.last_point = last;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      plateaus.note_request(req_data);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_set(int n);
      int shape, curv, tilt;
      logic [15:0] mag;
      logic signed [31:0] energy;
      shape = $urandom_range(3);
      curv = $urandom_range(2000);
      tilt = $urandom_range(40000) - 20000;
      for (int j = 0; j < n; j++) begin
         mag = ($urandom_range(3) == 0) ? 16'($urandom) :
               16'((j * 32768) / (n > 1 ? n - 1 : 1));
         case (shape)
            0: energy = $urandom;
            1: energy = $urandom_range(200) - 100;
            2: energy = curv * j * j + tilt * j + $urandom_range(curv);
            default: energy = (j % 3 == 0) ? 32'sd0 : $urandom_range(5000);
         endcase
         send_point(mag, energy, j == n - 1);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 22;
      sent = 0;
      stall_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // saturating slopes both ways
      send_point(16'd0, 32'sh80000000, 1'b0);
      send_point(16'd32768, 32'sh7fffffff, 1'b1);
      send_point(16'hffff, 32'sh7fffffff, 1'b0);
      send_point(16'd32768, 32'sh80000000, 1'b0);
      send_point(16'd0, 32'sh7fffffff, 1'b1);
      // single point gives nothing
      send_point(16'd100, 32'sd5, 1'b1);
      // equal slopes, nearest wins
      send_point(16'd0, 32'sd0, 1'b0);
      send_point(16'd1000, -32'sd10, 1'b0);
      send_point(16'd2000, -32'sd20, 1'b0);
      send_point(16'd3000, -32'sd30, 1'b1);
      // negative truncation toward zero
      send_point(16'd1, 32'sd0, 1'b0);
      send_point(16'd2, 32'sd7, 1'b0);
      send_point(16'd3, -32'sd7, 1'b1);

      send_set(STORE_DEPTH + 3);
      idle_pct = 66;
      while (sent < 146) begin
         if ($urandom_range(15) == 0) send_point(16'($urandom), $urandom, 1'b1);
         else send_set($urandom_range(2, 8));
      end
      idle_pct = 0;
      send_set(STORE_DEPTH);
      start = 1'b0;

      while (plateaus.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (plateaus.pending.size() != 0) begin
         $error("%0d expected results never arrived", plateaus.pending.size());
         plateaus.errors++;
      end
      $display("run covered %0d points and %0d plateau results, idle 22/66/0 percent",
               sent, plateaus.results);
      if (plateaus.errors == 0) $display("** magnetization_plateau_hull: PASSED **");
      else $display("** magnetization_plateau_hull: FAILED **");
      $finish;
   end
endmodule
